### src/rpwd_pkg.sv
`default_nettype none
package rpwd_pkg;

  localparam logic [15:0] TYPE_REL         = 16'd2;
  localparam logic [15:0] TYPE_ABS         = 16'd3;
  localparam logic [15:0] CODE_WHEEL       = 16'h0008;
  localparam logic [15:0] CODE_WHEEL_HIRES = 16'h000b;
  localparam logic [15:0] CODE_MISC        = 16'h0028;
  localparam int unsigned RING_W           = 11;
  localparam logic [RING_W-1:0] RING_RESET = 11'd12;
  localparam logic [0:0]  REG_RING_SIZE    = 1'b0;

  typedef struct packed {
    logic [15:0]        event_type;
    logic [15:0]        event_code;
    logic signed [31:0] event_value;
  } in_item_t;

  typedef struct packed {
    logic [15:0]        out_type;
    logic [15:0]        out_code;
    logic signed [31:0] out_value;
    logic               last_of_run;
  } out_item_t;

  typedef struct packed {
    logic        pass;
    logic        emit;
    logic [31:0] step;
    logic        track_d;
    logic [31:0] prev_d;
  } step_res_t;

endpackage
`default_nettype wire

### src/rpwd_step.sv
`default_nettype none
module rpwd_step (
  input  rpwd_pkg::in_item_t               item_i,
  input  logic                             tracking_i,
  input  logic [31:0]                      prev_i,
  input  logic [rpwd_pkg::RING_W-1:0]      detents_i,
  output rpwd_pkg::step_res_t              res_o
);

  logic        is_abs;
  logic        is_misc;
  logic        is_wheel;
  logic [31:0] value;
  logic [31:0] diff;
  logic        neg;
  logic [31:0] mag;
  logic        no_fold;
  logic [31:0] folded;
  logic [31:0] step;

  always_comb begin
    value    = item_i.event_value;
    is_abs   = (item_i.event_type == rpwd_pkg::TYPE_ABS);
    is_misc  = (item_i.event_code == rpwd_pkg::CODE_MISC) && (value != 32'd0);
    is_wheel = (item_i.event_code == rpwd_pkg::CODE_WHEEL);

    diff    = value - prev_i;
    neg     = diff[31];
    mag     = neg ? (32'd0 - diff) : diff;
    no_fold = ({mag, 1'b0} < {22'd0, detents_i});
    folded  = {21'd0, detents_i} - mag;
    if (no_fold) begin
      step = diff;
    end else if (neg) begin
      step = folded;
    end else begin
      step = 32'd0 - folded;
    end

    res_o.pass    = !is_abs;
    res_o.emit    = is_abs && !is_misc && is_wheel && tracking_i && (step != 32'd0);
    res_o.step    = step;
    res_o.track_d = tracking_i;
    res_o.prev_d  = prev_i;
    if (is_abs && is_misc) begin
      res_o.track_d = 1'b0;
      res_o.prev_d  = 32'd0;
    end else if (is_abs && is_wheel) begin
      res_o.track_d = 1'b1;
      res_o.prev_d  = value;
    end
  end

endmodule
`default_nettype wire

### src/ring_position_to_wheel_delta.sv
`default_nettype none
// Ring position to wheel delta: turns absolute ring positions (type 3, code 8)
// into relative wheel steps folded the short way around the ring, whose detent
// count is the APB register at address 0 (reset 12). A nonzero step gives two
// items, wheel (code 8) then hi-res wheel (code 0x0b, step*120); other
// non-absolute items pass through as one item, and other absolute items give
// none (code 0x28 with a nonzero value clears tracking). An item is taken
// into an input register and its results are registered into the output
// register when it retires. One item is accepted per cycle while in_stall_o
// is low; an item that gives two results holds the output register until both
// are taken, and the next item waits in the input register meanwhile.
module ring_position_to_wheel_delta (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  rpwd_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output rpwd_pkg::out_item_t  out_item_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  logic [rpwd_pkg::RING_W-1:0] ring_q;
  logic                        s1_valid_q;
  rpwd_pkg::in_item_t          s1_item_q;
  logic                        tracking_q, tracking_d;
  logic [31:0]                 prev_q, prev_d;
  logic                        out_valid_q;
  rpwd_pkg::out_item_t         out_q;
  logic                        hi_pending_q;
  logic [31:0]                 hi_step_q;
  rpwd_pkg::step_res_t         res;
  logic                        s1_go;
  logic                        out_take;
  logic                        in_take;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == rpwd_pkg::REG_RING_SIZE) ? {21'd0, ring_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_q <= rpwd_pkg::RING_RESET;
    end else if (psel && penable && pwrite && paddr[2] == rpwd_pkg::REG_RING_SIZE) begin
      ring_q <= pwdata[rpwd_pkg::RING_W-1:0];
    end
  end

  rpwd_step u_step (
    .item_i      (s1_item_q),
    .tracking_i  (tracking_q),
    .prev_i      (prev_q),
    .detents_i   (ring_q),
    .res_o       (res)
  );

  assign out_take   = out_valid_q && !out_stall_i;
  assign s1_go      = s1_valid_q && (!out_valid_q || (out_take && !hi_pending_q));
  assign in_stall_o = s1_valid_q && !s1_go;
  assign in_take    = in_valid_i && !in_stall_o;

  assign tracking_d = s1_go ? res.track_d : tracking_q;
  assign prev_d     = s1_go ? res.prev_d : prev_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      tracking_q <= 1'b0;
      prev_q     <= 32'd0;
    end else begin
      tracking_q <= tracking_d;
      prev_q     <= prev_d;
      if (in_take) begin
        s1_valid_q <= 1'b1;
      end else if (s1_go) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_item_q <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      hi_pending_q <= 1'b0;
    end else if (s1_go && (res.pass || res.emit)) begin
      out_valid_q  <= 1'b1;
      hi_pending_q <= res.emit;
    end else if (out_take) begin
      out_valid_q  <= hi_pending_q;
      hi_pending_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && res.pass) begin
      out_q.out_type    <= s1_item_q.event_type;
      out_q.out_code    <= s1_item_q.event_code;
      out_q.out_value   <= s1_item_q.event_value;
      out_q.last_of_run <= 1'b1;
    end else if (s1_go && res.emit) begin
      out_q.out_type    <= rpwd_pkg::TYPE_REL;
      out_q.out_code    <= rpwd_pkg::CODE_WHEEL;
      out_q.out_value   <= res.step;
      out_q.last_of_run <= 1'b0;
      hi_step_q         <= res.step;
    end else if (out_take && hi_pending_q) begin
      out_q.out_type    <= rpwd_pkg::TYPE_REL;
      out_q.out_code    <= rpwd_pkg::CODE_WHEEL_HIRES;
      // step * 120 = step * 128 - step * 8, low 32 bits
      out_q.out_value   <= {hi_step_q[24:0], 7'd0} - {hi_step_q[28:0], 3'd0};
      out_q.last_of_run <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_pending_has_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hi_pending_q |-> out_valid_q)
    else $error("hi-res result pending without a valid output");

  a_first_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.last_of_run) |-> hi_pending_q)
    else $error("non-final result without a pending hi-res result");

  a_hires_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_take && hi_pending_q) |=>
      (out_valid_o && out_item_o.last_of_run &&
       out_item_o.out_code == rpwd_pkg::CODE_WHEEL_HIRES))
    else $error("hi-res wheel item did not follow the wheel item");

  a_stall_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q))
    else $error("input stalled while the pipeline can move");

  a_state_only_on_go: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_go |=> ($stable(tracking_q) && $stable(prev_q)))
    else $error("tracking state changed without a retiring item");

endmodule
`default_nettype wire
